// ----- hw/rtl/alpha_blend_pixel_compositor_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pixel compositor.
// ----------------------------------------------------------------------------
`ifndef ALPHA_BLEND_PIXEL_COMPOSITOR_ASSERT_SVH
`define ALPHA_BLEND_PIXEL_COMPOSITOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ABPC_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ABPC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hw/rtl/abpc_pkg.sv -----
// ----------------------------------------------------------------------------
// abpc_pkg
// Types and constants shared by the pixel compositor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package abpc_pkg;

    localparam int PIX_W     = 32;
    localparam int LANE_W    = 8;
    localparam int LANES     = PIX_W / LANE_W;
    localparam int HIGH_SH   = 24;
    localparam int ADDR_W    = 4;
    localparam int APB_W     = 32;

    localparam logic [LANE_W-1:0] LANE_MAX = 8'hff;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ALPHA_POS  = 2'd0;
    localparam logic [1:0] REG_TINT_MODE  = 2'd1;
    localparam logic [1:0] REG_TINT_COLOR = 2'd2;

    // alpha position codes
    localparam logic [1:0] POS_NONE = 2'd0;
    localparam logic [1:0] POS_LOW  = 2'd1;
    localparam logic [1:0] POS_HIGH = 2'd2;

    // per-pixel action
    localparam logic [1:0] ACT_SKIP  = 2'd0;
    localparam logic [1:0] ACT_COPY  = 2'd1;
    localparam logic [1:0] ACT_BLEND = 2'd2;

    typedef struct packed {
        logic [1:0]       alpha_pos;
        logic             tint_mode;
        logic [PIX_W-1:0] tint_color;
    } t_cfg;

    function automatic logic has_alpha(input logic [1:0] pos);
        has_alpha = (pos == POS_LOW) || (pos == POS_HIGH);
    endfunction

    function automatic logic [LANE_W-1:0] alpha_of(input logic [1:0] pos,
                                                   input logic [PIX_W-1:0] pix);
        if (pos == POS_HIGH) begin
            alpha_of = pix[HIGH_SH +: LANE_W];
        end else begin
            alpha_of = pix[LANE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/abpc_regs.sv -----
// ----------------------------------------------------------------------------
// abpc_regs
// APB register file holding alpha position, tint mode and tint color.
// ----------------------------------------------------------------------------
`default_nettype none

module abpc_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [abpc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [abpc_pkg::APB_W-1:0]  pwdata,
    output logic      [abpc_pkg::APB_W-1:0]  prdata,
    output logic                            pready,
    output abpc_pkg::t_cfg                  o_cfg
);
    import abpc_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [1:0] idx;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (idx)
                REG_ALPHA_POS:  n_cfg.alpha_pos  = pwdata[1:0];
                REG_TINT_MODE:  n_cfg.tint_mode  = pwdata[0];
                REG_TINT_COLOR: n_cfg.tint_color = pwdata[PIX_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (idx)
            REG_ALPHA_POS:  prdata = {{(APB_W-2){1'b0}}, r_cfg.alpha_pos};
            REG_TINT_MODE:  prdata = {{(APB_W-1){1'b0}}, r_cfg.tint_mode};
            REG_TINT_COLOR: prdata = r_cfg.tint_color;
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hw/rtl/alpha_blend_pixel_compositor.sv -----
// Pixel compositor: one source/destination pair in per beat, one result pixel
// plus write enable out per beat, in order. A new pixel is taken every clock
// unless output back-pressure stalls the whole pipeline (without loss). There
// are four register stages: alpha scaling multiply, action decode, per-lane
// multiplies, lane sum and select. Configure only while idle.
// ----------------------------------------------------------------------------
// alpha_blend_pixel_compositor
// Source-over blend of 32-bit pixels with copy and tint modes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alpha_blend_pixel_compositor_assert.svh"

module alpha_blend_pixel_compositor (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // beat in: [31:0] source_pixel, [63:32] dest_pixel
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [2*abpc_pkg::PIX_W-1:0] i_s_tdata,
    // beat out: [31:0] result_pixel
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic      [abpc_pkg::PIX_W-1:0]   o_m_tdata,
    // [0] write_enable
    output logic                             o_m_tuser,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [abpc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [abpc_pkg::APB_W-1:0]   pwdata,
    output logic      [abpc_pkg::APB_W-1:0]   prdata,
    output logic                             pready
);
    import abpc_pkg::*;

    t_cfg cfg;

    abpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic en1, en2, en3, en4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign en4 = !r_v4 || i_m_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_s_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // stage 1: capture, scale source alpha by tint alpha
    logic [PIX_W-1:0]    r_src1, r_dst1;
    logic [LANE_W-1:0]   r_a1;
    logic [2*LANE_W-1:0] r_prod1;
    logic [LANE_W-1:0]   in_a, tint_a;

    assign in_a   = alpha_of(cfg.alpha_pos, i_s_tdata[PIX_W-1:0]);
    assign tint_a = alpha_of(cfg.alpha_pos, cfg.tint_color);

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_src1  <= i_s_tdata[PIX_W-1:0];
            r_dst1  <= i_s_tdata[2*PIX_W-1:PIX_W];
            r_a1    <= in_a;
            r_prod1 <= (2*LANE_W)'(in_a) * (2*LANE_W)'(tint_a);
        end
    end

    // stage 2: pick foreground, alpha and action
    logic [PIX_W-1:0]  r_fg2, r_dst2;
    logic [LANE_W-1:0] r_alpha2;
    logic [1:0]        r_act2;
    logic [PIX_W-1:0]  n_fg2;
    logic [LANE_W-1:0] n_alpha2;
    logic [1:0]        n_act2;
    logic [LANE_W-1:0] sa;

    assign sa = r_prod1[2*LANE_W-1:LANE_W];

    always_comb begin
        n_fg2    = r_src1;
        n_alpha2 = r_a1;
        n_act2   = ACT_SKIP;
        if (!cfg.tint_mode) begin
            if (!has_alpha(cfg.alpha_pos)) begin
                if (r_src1 != '0) n_act2 = ACT_COPY;
            end else if (r_a1 == LANE_MAX) begin
                n_act2 = ACT_COPY;
            end else if (r_a1 != '0) begin
                n_act2 = ACT_BLEND;
            end
        end else begin
            n_fg2    = cfg.tint_color;
            n_alpha2 = sa;
            if (!has_alpha(cfg.alpha_pos)) begin
                n_act2 = ACT_COPY;
            end else if (sa == LANE_MAX) begin
                n_act2 = ACT_COPY;
            end else if (sa != '0) begin
                n_act2 = ACT_BLEND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_fg2    <= n_fg2;
            r_dst2   <= r_dst1;
            r_alpha2 <= n_alpha2;
            r_act2   <= n_act2;
        end
    end

    // stage 3: per-lane products
    logic [PIX_W-1:0]    r_fg3, r_dst3;
    logic [1:0]          r_act3;
    logic [2*LANE_W-1:0] r_pf3 [LANES];
    logic [2*LANE_W-1:0] r_pb3 [LANES];
    logic [LANE_W-1:0]   inv_a;

    assign inv_a = LANE_MAX - r_alpha2;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_fg3  <= r_fg2;
            r_dst3 <= r_dst2;
            r_act3 <= r_act2;
            for (int i = 0; i < LANES; i++) begin
                r_pf3[i] <= (2*LANE_W)'(r_fg2[i*LANE_W +: LANE_W]) * (2*LANE_W)'(r_alpha2);
                r_pb3[i] <= (2*LANE_W)'(r_dst2[i*LANE_W +: LANE_W]) * (2*LANE_W)'(inv_a);
            end
        end
    end

    // stage 4: lane sums and result select
    logic [PIX_W-1:0]    r_res4;
    logic                r_we4;
    logic [PIX_W-1:0]    blend;
    logic [PIX_W-1:0]    n_res4;
    logic                n_we4;
    logic [2*LANE_W-1:0] lane_sum [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane_sum[i] = r_pf3[i] + r_pb3[i];
            blend[i*LANE_W +: LANE_W] = lane_sum[i][2*LANE_W-1:LANE_W];
        end
    end

    always_comb begin
        case (r_act3)
            ACT_COPY: begin
                n_res4 = r_fg3;
                n_we4  = 1'b1;
            end
            ACT_BLEND: begin
                n_res4 = blend;
                n_we4  = 1'b1;
            end
            default: begin
                n_res4 = r_dst3;
                n_we4  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_res4 <= n_res4;
            r_we4  <= n_we4;
        end
    end

    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = r_res4;
    assign o_m_tuser  = r_we4;

    `ABPC_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_v1,
        "accepted beat did not enter stage 1")
    `ABPC_ASSERT_SAME(a_blend_alpha, i_clk, i_rst_n, r_v2 && (r_act2 == ACT_BLEND),
        (r_alpha2 != '0) && (r_alpha2 != LANE_MAX), "blend with edge alpha")
    `ABPC_ASSERT_SAME(a_tint_noalpha, i_clk, i_rst_n,
        o_m_tvalid && cfg.tint_mode && !has_alpha(cfg.alpha_pos), o_m_tuser,
        "tint without alpha must write")

endmodule

`default_nettype wire
